[design/cnc_pkg.sv]
`timescale 1ns / 1ps

package cnc_pkg;

  localparam int ACC_W   = 20;
  localparam int ANGLE_W = 12;
  localparam int XY_W    = 13;
  localparam int OUT_W   = 13;
  localparam int GAIN_W  = 11;
  localparam int SUM_W   = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BINARY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAIN    = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 11'd1243;

  localparam logic signed [SUM_W-1:0] HALF_TURN = 14'sd2048;
  localparam logic signed [SUM_W-1:0] OUT_MIN   = -14'sd2048;
  localparam logic signed [SUM_W-1:0] OUT_MAX   = 14'sd4095;

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ANGLE_W-1:0] ang;
    logic                      inv;
  } sample_t;

  function automatic logic signed [ANGLE_W-1:0] atan_units(input logic [3:0] idx);
    logic signed [ANGLE_W-1:0] v;
    begin
      case (idx)
        4'd0:    v = 12'sd512;
        4'd1:    v = 12'sd302;
        4'd2:    v = 12'sd160;
        4'd3:    v = 12'sd81;
        4'd4:    v = 12'sd41;
        4'd5:    v = 12'sd20;
        4'd6:    v = 12'sd10;
        4'd7:    v = 12'sd5;
        4'd8:    v = 12'sd3;
        4'd9:    v = 12'sd1;
        4'd10:   v = 12'sd1;
        default: v = 12'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

[design/cnc_phase.sv]
`timescale 1ns / 1ps

module cnc_phase (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  input  logic [cnc_pkg::ACC_W-1:0]           phase_step,
  input  logic [cnc_pkg::GAIN_W-1:0]          start_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cnc_pkg::sample_t                    out_smp
);

  logic [cnc_pkg::ACC_W-1:0]   acc_r, acc_nxt, acc_use;
  logic                        vld_r;
  cnc_pkg::sample_t            smp_r, smp_nxt;
  logic [cnc_pkg::ANGLE_W-1:0] u;
  logic                        inv;
  logic                        take;

  assign in_ready = !vld_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    acc_use     = restart ? '0 : acc_r;
    acc_nxt     = acc_use + phase_step;
    u           = acc_use[cnc_pkg::ACC_W-1 -: cnc_pkg::ANGLE_W];
    // The second and third quadrants are moved by half a turn and flagged for negation.
    inv         = u[cnc_pkg::ANGLE_W-1] ^ u[cnc_pkg::ANGLE_W-2];
    smp_nxt.x   = cnc_pkg::XY_W'({2'b00, start_gain});
    smp_nxt.y   = '0;
    smp_nxt.ang = signed'({u[cnc_pkg::ANGLE_W-1] ^ inv, u[cnc_pkg::ANGLE_W-2:0]});
    smp_nxt.inv = inv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= acc_nxt;
      end
      if (in_ready) begin
        vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp_r <= smp_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_smp   = smp_r;

endmodule

[design/cnc_cell.sv]
`timescale 1ns / 1ps

module cnc_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cnc_pkg::sample_t in_smp,
  output logic             out_valid,
  input  logic             out_ready,
  output cnc_pkg::sample_t out_smp
);

  logic                                vld_r;
  cnc_pkg::sample_t                    smp_r, smp_nxt;
  logic signed [cnc_pkg::XY_W-1:0]     xs, ys;
  logic signed [cnc_pkg::ANGLE_W-1:0]  step;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    xs   = in_smp.x >>> STAGE;
    ys   = in_smp.y >>> STAGE;
    step = cnc_pkg::atan_units(4'(STAGE));
    smp_nxt.inv = in_smp.inv;
    if (!in_smp.ang[cnc_pkg::ANGLE_W-1]) begin
      smp_nxt.x   = in_smp.x - ys;
      smp_nxt.y   = in_smp.y + xs;
      smp_nxt.ang = in_smp.ang - step;
    end else begin
      smp_nxt.x   = in_smp.x + ys;
      smp_nxt.y   = in_smp.y - xs;
      smp_nxt.ang = in_smp.ang + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= smp_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_smp   = smp_r;

endmodule

[design/cnc_post.sv]
`timescale 1ns / 1ps

module cnc_post (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cnc_pkg::sample_t                   in_smp,
  input  logic                               offset_binary,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cnc_pkg::OUT_W-1:0]   cos_out,
  output logic signed [cnc_pkg::OUT_W-1:0]   sin_out
);

  logic                              vld_r;
  logic signed [cnc_pkg::OUT_W-1:0]  cos_r, sin_r, cos_nxt, sin_nxt;
  logic signed [cnc_pkg::SUM_W-1:0]  xe, ye, bias;

  function automatic logic signed [cnc_pkg::OUT_W-1:0] clamp(
    input logic signed [cnc_pkg::SUM_W-1:0] v);
    logic signed [cnc_pkg::SUM_W-1:0] c;
    begin
      if (v < cnc_pkg::OUT_MIN) begin
        c = cnc_pkg::OUT_MIN;
      end else if (v > cnc_pkg::OUT_MAX) begin
        c = cnc_pkg::OUT_MAX;
      end else begin
        c = v;
      end
      return c[cnc_pkg::OUT_W-1:0];
    end
  endfunction

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    bias = offset_binary ? cnc_pkg::HALF_TURN : '0;
    xe   = cnc_pkg::SUM_W'(in_smp.x);
    ye   = cnc_pkg::SUM_W'(in_smp.y);
    if (in_smp.inv) begin
      xe = -xe;
      ye = -ye;
    end
    cos_nxt = clamp(xe + bias);
    sin_nxt = clamp(ye + bias);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_valid = vld_r;
  assign cos_out   = cos_r;
  assign sin_out   = sin_r;

endmodule

[design/cordic_nco_sine_cosine.sv]
// CORDIC oscillator: one cosine/sine sample pair for every input beat.
// Input channel (in_): each beat is a tick; in_tdata[0] is restart, which clears
// the 20-bit phase accumulator before this sample so that it is taken at phase zero.
// Output channel (out_): out_tdata[12:0] is the cosine, out_tdata[25:13] the sine,
// both 13-bit two's complement, or offset binary when that register is set.
// Configuration channel (cfg_): index 0 is the phase step, 1 the offset-binary
// flag, 2 the start gain; cfg_ready is always high and writes are registered.
// Registers should be written only while no samples are in flight.
// The pipeline is one phase stage, one CORDIC cell per iteration, and the
// output register. Throughput is one beat per cycle while out_tready stays high.
// Every stage holds its beat while the next one is full and stalled, so when the
// receiver drops out_tready the chain fills and in_tready falls only once no
// stage has a gap left; nothing is lost or repeated.
// Reset clears the accumulator, the phase step and offset flag, sets the start
// gain to 1243 and empties every stage.
`timescale 1ns / 1ps

module cordic_nco_sine_cosine #(
  parameter int ITERATIONS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] restart, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [12:0] cos_out, [25:13] sin_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cnc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [cnc_pkg::ACC_W-1:0]          phase_step_r;
  logic                               offset_binary_r;
  logic [cnc_pkg::GAIN_W-1:0]         start_gain_r;
  logic                               vld  [ITERATIONS+1];
  logic                               rdy  [ITERATIONS+1];
  cnc_pkg::sample_t                   smp  [ITERATIONS+1];
  logic signed [cnc_pkg::OUT_W-1:0]   cos_out, sin_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      offset_binary_r <= 1'b0;
      start_gain_r    <= cnc_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cnc_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_data[cnc_pkg::ACC_W-1:0];
        cnc_pkg::REG_OFFSET_BINARY: offset_binary_r <= cfg_data[0];
        cnc_pkg::REG_START_GAIN:    start_gain_r    <= cfg_data[cnc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  cnc_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .restart    (in_tdata[0]),
    .phase_step (phase_step_r),
    .start_gain (start_gain_r),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .out_smp    (smp[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    cnc_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_smp    (smp[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_smp   (smp[i+1])
    );
  end

  cnc_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (vld[ITERATIONS]),
    .in_ready      (rdy[ITERATIONS]),
    .in_smp        (smp[ITERATIONS]),
    .offset_binary (offset_binary_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .cos_out       (cos_out),
    .sin_out       (sin_out)
  );

  assign out_tdata = {6'b0, sin_out, cos_out};

endmodule

[design/cnc_checker.sv]
`timescale 1ns / 1ps

module cnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled output beat must stay put with the same samples.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // Samples never fall below -2048 and the padding stays zero.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[12] && !out_tdata[11]) &&
                   !(out_tdata[25] && !out_tdata[24]) && out_tdata[31:26] == 6'b0)
    else $error("sample out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // With the output side free, the input side can never be stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!out_tvalid) && $past(out_tready) |-> in_tready)
    else $error("input stalled while output empty");

endmodule

bind cordic_nco_sine_cosine cnc_checker u_cnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
